@@ rtl/ale_pkg.sv @@
// ----------------------------------------------------------------------------
// ale_pkg
// Shared constants, codes and types for the assembly line encoder.
// ----------------------------------------------------------------------------
package ale_pkg;

    // Line and token limits
    localparam int LINE_CHARS  = 255;
    localparam int TOKEN_LIMIT = 10;
    localparam int LINE_W      = $clog2(LINE_CHARS + 1);
    localparam int TOK_W       = $clog2(TOKEN_LIMIT + 1);

    localparam int MNEM_CHARS  = 5;
    localparam int MNEM_W      = 8 * MNEM_CHARS;
    localparam int NUM_W       = 14;
    localparam int TLEN_W      = 3;     // token length, saturating; only 0..5 matter
    localparam int OPER_N      = 3;

    // Numeric saturation limits
    localparam logic [NUM_W-1:0] MAG_SAT = 14'd8192;
    localparam logic [NUM_W-1:0] POS_MAX = 14'd8191;

    // Characters
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LOW_R = 8'h72;

    // Number scanner phases
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_JUNK  = 2'd3;

    // Packed lower-case mnemonics
    localparam logic [MNEM_W-1:0] MN_ADD   = 40'h00_0061_6464;
    localparam logic [MNEM_W-1:0] MN_AND   = 40'h00_0061_6E64;
    localparam logic [MNEM_W-1:0] MN_OR    = 40'h00_0000_6F72;
    localparam logic [MNEM_W-1:0] MN_ADDI  = 40'h00_6164_6469;
    localparam logic [MNEM_W-1:0] MN_LOAD  = 40'h00_6C6F_6164;
    localparam logic [MNEM_W-1:0] MN_STORE = 40'h73_746F_7265;
    localparam logic [MNEM_W-1:0] MN_JUMP  = 40'h00_6A75_6D70;
    localparam logic [MNEM_W-1:0] MN_BNE   = 40'h00_0062_6E65;
    localparam logic [MNEM_W-1:0] MN_BEQ   = 40'h00_0062_6571;
    localparam logic [MNEM_W-1:0] MN_BLT   = 40'h00_0062_6C74;
    localparam logic [MNEM_W-1:0] MN_BGT   = 40'h00_0062_6774;
    localparam logic [MNEM_W-1:0] MN_LI    = 40'h00_0000_6C69;
    localparam logic [MNEM_W-1:0] MN_NOT   = 40'h00_006E_6F74;

    // Opcodes
    localparam logic [3:0] OP_ADD   = 4'h0;
    localparam logic [3:0] OP_ADDI  = 4'h1;
    localparam logic [3:0] OP_LOAD  = 4'h2;
    localparam logic [3:0] OP_STORE = 4'h3;
    localparam logic [3:0] OP_JUMP  = 4'h4;
    localparam logic [3:0] OP_BNE   = 4'h5;
    localparam logic [3:0] OP_BEQ   = 4'h6;
    localparam logic [3:0] OP_BLT   = 4'h7;
    localparam logic [3:0] OP_BGT   = 4'h8;
    localparam logic [3:0] OP_LI    = 4'h9;
    localparam logic [3:0] OP_AND   = 4'hA;
    localparam logic [3:0] OP_OR    = 4'hB;
    localparam logic [3:0] OP_NOT   = 4'hC;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_BAD_REG = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    // Completed line, handed from tokenizer to encoder
    typedef struct packed {
        logic [TOK_W-1:0]             tokens;
        logic [MNEM_W-1:0]            mnem;
        logic                         overlong;
        logic [OPER_N-1:0][2:0]       regs;   // bit 2 valid, bits 1:0 code
        logic [OPER_N-1:0][NUM_W-1:0] nums;   // two's complement
    } t_line;

endpackage

@@ rtl/ale_tokenizer.sv @@
// ----------------------------------------------------------------------------
// ale_tokenizer
// Per-character line state: comments, token split, mnemonic capture, register
// and decimal operand scan; reports the closed line at line end or length cap.
// ----------------------------------------------------------------------------
module ale_tokenizer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_char_code,
    input  logic           i_line_end,
    output logic           o_done,
    output ale_pkg::t_line o_line
);
    import ale_pkg::*;

    logic                         r_comment, n_comment;
    logic                         r_inside, n_inside;
    logic [TOK_W-1:0]             r_tokens, n_tokens;
    logic [LINE_W-1:0]            r_len, n_len;
    logic [MNEM_W-1:0]            r_mnem, n_mnem;
    logic                         r_overlong, n_overlong;
    logic [TLEN_W-1:0]            r_tlen, n_tlen;
    logic [OPER_N-1:0][2:0]       r_regs, n_regs;
    logic [OPER_N-1:0][NUM_W-1:0] r_nums, n_nums;
    logic [2:0]                   r_scan, n_scan;
    logic                         r_dropped, n_dropped;

    logic [7:0]        c;
    logic              is_delim, is_stop, is_digit, do_close, done;
    logic [1:0]        k, phase;
    logic              neg, slot_ok;
    logic [NUM_W-1:0]  mag;
    logic [NUM_W+2:0]  prod;
    logic [LINE_W:0]   len_inc;
    logic [3:0]        dval;

    always_comb begin
        c = i_char_code;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            c = c + 8'd32;
        end
        is_stop  = (i_char_code == CH_HASH) || (i_char_code == CH_NUL);
        is_delim = (i_char_code == CH_COMMA) || (i_char_code == CH_SPACE) ||
                   (i_char_code == CH_TAB) || (i_char_code == CH_LF) ||
                   (i_char_code == CH_CR) || (i_char_code == CH_VT) ||
                   (i_char_code == CH_FF);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        dval     = 4'(c - CH_ZERO);

        n_comment  = r_comment;
        n_inside   = r_inside;
        n_tokens   = r_tokens;
        n_mnem     = r_mnem;
        n_overlong = r_overlong;
        n_tlen     = r_tlen;
        n_regs     = r_regs;
        n_nums     = r_nums;
        n_scan     = r_scan;
        n_dropped  = r_dropped;
        do_close   = 1'b0;
        slot_ok    = 1'b0;
        k          = 2'd0;
        phase      = 2'd0;
        neg        = 1'b0;
        mag        = '0;
        prod       = '0;

        if (!r_comment) begin
            if (is_stop) begin
                do_close  = 1'b1;
                n_comment = 1'b1;
            end else if (is_delim) begin
                do_close = 1'b1;
            end else begin
                // token start
                if (!r_inside) begin
                    n_inside = 1'b1;
                    n_tlen   = '0;
                    n_scan   = '0;
                    if (r_tokens < TOK_W'(TOKEN_LIMIT)) begin
                        n_tokens  = r_tokens + 1'b1;
                        n_dropped = 1'b0;
                        if (n_tokens >= TOK_W'(2) && n_tokens <= TOK_W'(4)) begin
                            k         = 2'(n_tokens - TOK_W'(2));
                            n_regs[k] = '0;
                            n_nums[k] = '0;
                        end
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
                // character feed
                if (!n_dropped) begin
                    if (n_tokens == TOK_W'(1)) begin
                        if (n_tlen < TLEN_W'(MNEM_CHARS)) begin
                            n_mnem = {n_mnem[MNEM_W-9:0], c};
                        end else begin
                            n_overlong = 1'b1;
                        end
                    end else if (n_tokens >= TOK_W'(2) && n_tokens <= TOK_W'(4)) begin
                        k = 2'(n_tokens - TOK_W'(2));
                        if (n_tlen == TLEN_W'(0)) begin
                            n_regs[k] = (c == CH_LOW_R) ? 3'b100 : 3'b000;
                        end else if (n_tlen == TLEN_W'(1)) begin
                            n_regs[k] = (n_regs[k][2] && c >= CH_ZERO && c <= CH_THREE) ?
                                        {1'b1, c[1:0]} : 3'b000;
                        end else begin
                            n_regs[k] = 3'b000;
                        end
                        phase = n_scan[1:0];
                        neg   = n_scan[2];
                        mag   = n_nums[k];
                        if (phase == PH_START && (c == CH_MINUS || c == CH_PLUS)) begin
                            phase = PH_SIGN;
                            neg   = (c == CH_MINUS);
                        end else if ((phase == PH_START || phase == PH_SIGN) && is_digit) begin
                            mag   = NUM_W'(dval);
                            phase = PH_DIGIT;
                        end else if (phase == PH_DIGIT && is_digit) begin
                            prod = {mag, 3'b000} + {2'b00, mag, 1'b0} + (NUM_W+3)'(dval);
                            mag  = (prod > (NUM_W+3)'(MAG_SAT)) ? MAG_SAT : prod[NUM_W-1:0];
                        end else begin
                            phase = PH_JUNK;
                        end
                        n_nums[k] = mag;
                        n_scan    = {neg, phase};
                    end
                end
                if (n_tlen != '1) begin
                    n_tlen = n_tlen + 1'b1;
                end
            end
        end

        len_inc = {1'b0, r_len} + 1'b1;
        done    = i_line_end || (len_inc >= (LINE_W+1)'(LINE_CHARS));
        n_len   = len_inc[LINE_W-1:0];
        if (done) begin
            do_close = 1'b1;
        end

        // token close
        if (do_close) begin
            slot_ok = n_inside && !n_dropped && n_tokens >= TOK_W'(2) &&
                      n_tokens <= TOK_W'(4);
            if (slot_ok) begin
                k = 2'(n_tokens - TOK_W'(2));
                if (n_tlen != TLEN_W'(2)) begin
                    n_regs[k] = 3'b000;
                end
                if (n_scan[2]) begin
                    n_nums[k] = NUM_W'(0) - n_nums[k];
                end else if (n_nums[k] > POS_MAX) begin
                    n_nums[k] = POS_MAX;
                end
            end
            n_inside = 1'b0;
        end

        o_done          = done;
        o_line.tokens   = n_tokens;
        o_line.mnem     = n_mnem;
        o_line.overlong = n_overlong;
        o_line.regs     = n_regs;
        o_line.nums     = n_nums;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comment  <= 1'b0;
            r_inside   <= 1'b0;
            r_tokens   <= '0;
            r_len      <= '0;
            r_mnem     <= '0;
            r_overlong <= 1'b0;
            r_tlen     <= '0;
            r_regs     <= '0;
            r_nums     <= '0;
            r_scan     <= '0;
            r_dropped  <= 1'b0;
        end else if (i_accept) begin
            if (done) begin
                r_comment  <= 1'b0;
                r_inside   <= 1'b0;
                r_tokens   <= '0;
                r_len      <= '0;
                r_mnem     <= '0;
                r_overlong <= 1'b0;
                r_tlen     <= '0;
                r_regs     <= '0;
                r_nums     <= '0;
                r_scan     <= '0;
                r_dropped  <= 1'b0;
            end else begin
                r_comment  <= n_comment;
                r_inside   <= n_inside;
                r_tokens   <= n_tokens;
                r_len      <= n_len;
                r_mnem     <= n_mnem;
                r_overlong <= n_overlong;
                r_tlen     <= n_tlen;
                r_regs     <= n_regs;
                r_nums     <= n_nums;
                r_scan     <= n_scan;
                r_dropped  <= n_dropped;
            end
        end
    end

endmodule

@@ rtl/ale_encoder.sv @@
// ----------------------------------------------------------------------------
// ale_encoder
// Matches the mnemonic and operand count of a closed line, checks
// registers and immediate ranges, and holds the result in a register.
// ----------------------------------------------------------------------------
module ale_encoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_take,
    input  ale_pkg::t_line i_line,
    output logic           o_valid,
    output logic [15:0]    o_word,
    output logic [2:0]     o_status
);
    import ale_pkg::*;

    logic                r_valid;
    logic [15:0]         r_word, n_word;
    logic [2:0]          r_status, n_status;
    logic [MNEM_W-1:0]   m;
    logic [3:0]          op;
    logic                is_rrr, is_rri;
    logic                fit8_1, fit8_2, fit12_0;
    logic [2:0]          rg0, rg1, rg2;

    always_comb begin
        m   = i_line.overlong ? '1 : i_line.mnem;
        rg0 = i_line.regs[0];
        rg1 = i_line.regs[1];
        rg2 = i_line.regs[2];
        // signed 8-bit / 12-bit fit: upper bits are a sign extension
        fit8_1  = (&i_line.nums[1][NUM_W-1:7]) || !(|i_line.nums[1][NUM_W-1:7]);
        fit8_2  = (&i_line.nums[2][NUM_W-1:7]) || !(|i_line.nums[2][NUM_W-1:7]);
        fit12_0 = (&i_line.nums[0][NUM_W-1:11]) || !(|i_line.nums[0][NUM_W-1:11]);

        is_rrr = 1'b1;
        is_rri = 1'b1;
        op     = OP_ADD;
        if (m == MN_ADD) begin
            op = OP_ADD;   is_rri = 1'b0;
        end else if (m == MN_AND) begin
            op = OP_AND;   is_rri = 1'b0;
        end else if (m == MN_OR) begin
            op = OP_OR;    is_rri = 1'b0;
        end else if (m == MN_ADDI) begin
            op = OP_ADDI;  is_rrr = 1'b0;
        end else if (m == MN_LOAD) begin
            op = OP_LOAD;  is_rrr = 1'b0;
        end else if (m == MN_STORE) begin
            op = OP_STORE; is_rrr = 1'b0;
        end else if (m == MN_BNE) begin
            op = OP_BNE;   is_rrr = 1'b0;
        end else if (m == MN_BEQ) begin
            op = OP_BEQ;   is_rrr = 1'b0;
        end else if (m == MN_BLT) begin
            op = OP_BLT;   is_rrr = 1'b0;
        end else if (m == MN_BGT) begin
            op = OP_BGT;   is_rrr = 1'b0;
        end else begin
            is_rrr = 1'b0; is_rri = 1'b0;
        end

        n_word   = '0;
        n_status = ST_UNKNOWN;
        if (i_line.tokens == TOK_W'(0)) begin
            n_status = ST_EMPTY;
        end else if (i_line.tokens == TOK_W'(4) && is_rrr) begin
            if (!(rg0[2] && rg1[2] && rg2[2])) begin
                n_status = ST_BAD_REG;
            end else begin
                n_status = ST_OK;
                n_word   = {op, rg0[1:0], rg1[1:0], rg2[1:0], 6'b000000};
            end
        end else if (i_line.tokens == TOK_W'(4) && is_rri) begin
            if (!(rg0[2] && rg1[2])) begin
                n_status = ST_BAD_REG;
            end else if (!fit8_2) begin
                n_status = ST_RANGE;
            end else begin
                n_status = ST_OK;
                n_word   = {op, rg0[1:0], rg1[1:0], i_line.nums[2][7:0]};
            end
        end else if (i_line.tokens == TOK_W'(2) && m == MN_JUMP) begin
            if (!fit12_0) begin
                n_status = ST_RANGE;
            end else begin
                n_status = ST_OK;
                n_word   = {OP_JUMP, i_line.nums[0][11:0]};
            end
        end else if (i_line.tokens == TOK_W'(3) && m == MN_LI) begin
            if (!rg0[2]) begin
                n_status = ST_BAD_REG;
            end else if (!fit8_1) begin
                n_status = ST_RANGE;
            end else begin
                n_status = ST_OK;
                n_word   = {OP_LI, rg0[1:0], 2'b00, i_line.nums[1][7:0]};
            end
        end else if (i_line.tokens == TOK_W'(3) && m == MN_NOT) begin
            if (!(rg0[2] && rg1[2])) begin
                n_status = ST_BAD_REG;
            end else begin
                n_status = ST_OK;
                n_word   = {OP_NOT, rg0[1:0], 2'b00, rg1[1:0], 6'b000000};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_load || (r_valid && !i_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word   <= n_word;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_word   = r_word;
    assign o_status = r_status;

endmodule

@@ rtl/assembly_line_encoder_top.sv @@
// ----------------------------------------------------------------------------
// assembly_line_encoder_top
// Streams assembly source one character per transaction and returns one
// encoded 16-bit instruction word with a status at every line end.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-----------------------------------
//  input    | in        | i_valid / o_stall  | i_char_code[7:0], i_line_end
//  result   | out       | o_valid / i_stall  | o_instruction_word[15:0], o_status[2:0]
//
//  One character is taken every cycle while o_stall is low; the tokenizer
//  state updates in the same cycle it is accepted. A line result passes
//  through the line register and then the encoder's result register,
//  moving on only while the result register is free.
//  Reset (i_rst_n low, synchronous) clears the line state and both valid flags.
//  With the result stalled, characters keep flowing until both the line
//  register and the result register hold a line; then o_stall rises.
//
module assembly_line_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_line_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_instruction_word,
    output logic [2:0]  o_status
);
    import ale_pkg::*;

    logic  accept;
    logic  line_done;
    t_line line_now;

    // Line register between tokenizer and encoder
    logic  r_line_valid;
    t_line r_line;

    logic  out_free;
    logic  line_move;

    // Result register can take a new line when empty or being drained
    assign out_free  = !o_valid || !i_stall;
    assign line_move = r_line_valid && out_free;
    assign o_stall   = r_line_valid && !out_free;
    assign accept    = i_valid && !o_stall;

    ale_tokenizer u_tokenizer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_char_code),
        .i_line_end  (i_line_end),
        .o_done      (line_done),
        .o_line      (line_now)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid <= 1'b0;
        end else begin
            r_line_valid <= (accept && line_done) || (r_line_valid && !out_free);
        end
    end

    // Payload: loaded only on a closing transaction
    always_ff @(posedge i_clk) begin
        if (accept && line_done) begin
            r_line <= line_now;
        end
    end

    ale_encoder u_encoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (line_move),
        .i_take   (!i_stall),
        .i_line   (r_line),
        .o_valid  (o_valid),
        .o_word   (o_instruction_word),
        .o_status (o_status)
    );

endmodule
